// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(prop)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ===== sv/lbsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lbsm_pkg
// types and constants of the skinning matrix blend core
// ----------------------------------------------------------------------------
package lbsm_pkg;

    localparam int unsigned FRAC_W = 16;
    localparam int unsigned SUM_W  = 18;
    localparam int unsigned WGT_W  = 17;
    localparam int unsigned NUM_INF = 4;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_BLEND = 1'b1;

    localparam logic [0:0] REG_BAD_SCALE_CHECK = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MAC,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        command;
        logic [6:0]  joint_entry;
        logic [3:0]  element_slot;
        logic signed [31:0] element_value;
        logic [23:0] influence_a;
        logic [23:0] influence_b;
        logic [23:0] influence_c;
        logic [23:0] influence_d;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  row_number;
        logic signed [31:0] col_zero;
        logic signed [31:0] col_one;
        logic signed [31:0] col_two;
        logic signed [31:0] col_three;
        logic        last_row;
        logic        weights_bad;
    } t_out_beat;

    typedef struct packed {
        logic                                start;
        logic [NUM_INF-1:0][FRAC_W-1:0]      frac;
        logic [SUM_W-1:0]                    sum;
    } t_div_req;

    typedef struct packed {
        logic                                busy;
        logic                                done;
        logic [NUM_INF-1:0][WGT_W-1:0]       w;
    } t_div_rsp;

endpackage

// ===== sv/linear_blend_skin_matrix_core.sv =====
// ----------------------------------------------------------------------------
// linear_blend_skin_matrix_core
// four-influence skinning matrix blend over a local joint palette
// ----------------------------------------------------------------------------
// input channel i_in_valid / o_in_stall carries load beats and blend beats.
// a load beat writes one palette element; load beats are taken back to back while idle.
// a blend beat clamps the four joint indices, normalizes the weights in a
// 17-step divider (skipped on a zero sum, then weights 1,0,0,0), and walks
// the palette memory one matrix row per read: four reads per result row,
// each through a 3-stage read, multiply, accumulate pipe, then round and
// saturate into the output register.
// the input stalls until the last row of a vertex is loaded into the output
// register, as the palette memory has a single read port and the divider
// is bit-serial.
// output channel o_out_valid / i_out_stall gives four row beats per vertex;
// a stalled row beat holds, and the next row waits before it is loaded.
// reset clears control and sets bad_scale_check; palette contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_blend_skin_matrix_core
    import lbsm_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = 128,
    parameter int unsigned ELEMENT_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_beat    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_beat   o_out
);

    localparam int unsigned ELEM_W = (ELEMENT_BITS < 32) ? ELEMENT_BITS : 32;
    localparam int unsigned EW     = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int unsigned AW     = EW + 2;
    localparam int unsigned DEPTH  = PALETTE_ENTRIES * 4;
    localparam int unsigned PW     = ELEM_W + WGT_W + 1;
    localparam int unsigned ACCW   = PW + 2;
    localparam int unsigned RW     = ACCW - 16;
    localparam logic [8:0]  LAST_ENTRY = 9'(PALETTE_ENTRIES - 1);
    localparam logic signed [RW-1:0] SAT_HI = RW'((64'd1 << (ELEM_W - 1)) - 64'd1);
    localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

    // configuration
    logic r_check;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check <= 1'b1;
        end else if (psel && penable && pwrite && (paddr[2] == REG_BAD_SCALE_CHECK)) begin
            r_check <= pwdata[0];
        end
    end
    assign prdata = (paddr[2] == REG_BAD_SCALE_CHECK) ? {31'd0, r_check} : 32'd0;

    // palette memory, one row of four elements per word
    logic [4*ELEM_W-1:0] mem [DEPTH];
    logic [4*ELEM_W-1:0] r_rdata;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [1:0]          mem_lane;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [8:0]          load_entry;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr][mem_lane*ELEM_W +: ELEM_W] <= i_in.element_value[ELEM_W-1:0];
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // control
    t_state r_state, n_state;
    logic [EW-1:0]     r_idx [NUM_INF];
    logic [WGT_W-1:0]  r_w   [NUM_INF];
    logic              r_bad;
    logic [1:0]        r_row, n_row;
    logic [1:0]        r_k, n_k;
    logic              r_rd_valid;
    logic [1:0]        r_rd_k;
    logic              r_p_valid;
    logic signed [PW-1:0]   r_p   [4];
    logic signed [ACCW-1:0] r_acc [4];
    logic              r_out_valid;
    t_out_beat         r_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic              in_acc;
    logic              blend_go;
    logic              out_load;
    logic              out_free;
    logic [SUM_W-1:0]  in_sum;
    logic [23:0]       inf [NUM_INF];
    logic [EW-1:0]     in_idx [NUM_INF];
    logic signed [31:0] col [4];

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        logic [8:0] j;
        inf[0] = i_in.influence_a;
        inf[1] = i_in.influence_b;
        inf[2] = i_in.influence_c;
        inf[3] = i_in.influence_d;
        in_sum = '0;
        for (int k = 0; k < NUM_INF; k++) begin
            j = {1'b0, inf[k][23:16]};
            if (j > LAST_ENTRY) begin
                j = LAST_ENTRY;
            end
            in_idx[k]        = j[EW-1:0];
            div_req.frac[k]  = inf[k][15:0];
            in_sum           = in_sum + SUM_W'(inf[k][15:0]);
        end
        div_req.sum   = in_sum;
        blend_go      = in_acc && (i_in.command == CMD_BLEND);
        div_req.start = blend_go && (in_sum != '0);
    end

    assign load_entry = {2'b00, i_in.joint_entry};
    assign mem_we    = in_acc && (i_in.command == CMD_LOAD) && (load_entry <= LAST_ENTRY);
    assign mem_waddr = {load_entry[EW-1:0], i_in.element_slot[3:2]};
    assign mem_lane  = i_in.element_slot[1:0];
    assign mem_re    = (r_state == S_MAC);
    assign mem_raddr = {r_idx[r_k], r_row};

    lbsm_wdiv u_wdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_k      = r_k;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (blend_go) begin
                    n_state = (in_sum != '0) ? S_DIV : S_MAC;
                    n_row   = 2'd0;
                    n_k     = 2'd0;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_valid && !r_p_valid) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_row    = r_row + 2'd1;
                    n_state  = (r_row == 2'd3) ? S_IDLE : S_MAC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_valid  <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= mem_re;
            r_p_valid  <= r_rd_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // round half up and saturate
    always_comb begin
        logic signed [ACCW-1:0] t;
        logic signed [RW-1:0]   q;
        for (int c = 0; c < 4; c++) begin
            t = r_acc[c] + ACCW'(32768);
            q = RW'(t >>> 16);
            if (q > SAT_HI) begin
                q = SAT_HI;
            end else if (q < SAT_LO) begin
                q = SAT_LO;
            end
            col[c] = 32'(signed'(q[ELEM_W-1:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_k    <= n_k;
        r_rd_k <= r_k;
        if (blend_go) begin
            for (int k = 0; k < NUM_INF; k++) begin
                r_idx[k] <= in_idx[k];
                r_w[k]   <= (k == 0) ? WGT_W'(65536) : '0;
            end
            r_bad <= (in_sum == '0) && r_check;
        end else if (div_rsp.done) begin
            for (int k = 0; k < NUM_INF; k++) begin
                r_w[k] <= div_rsp.w[k];
            end
        end
        for (int c = 0; c < 4; c++) begin
            r_p[c] <= $signed(r_rdata[c*ELEM_W +: ELEM_W]) * $signed({1'b0, r_w[r_rd_k]});
            if (blend_go || out_load) begin
                r_acc[c] <= '0;
            end else if (r_p_valid) begin
                r_acc[c] <= r_acc[c] + ACCW'(r_p[c]);
            end
        end
        if (out_load) begin
            r_out.row_number  <= r_row;
            r_out.col_zero    <= col[0];
            r_out.col_one     <= col[1];
            r_out.col_two     <= col[2];
            r_out.col_three   <= col[3];
            r_out.last_row    <= (r_row == 2'd3);
            r_out.weights_bad <= r_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_CLK(a_load_idle, i_clk, i_rst_n, mem_we |-> (r_state == S_IDLE))
    `ASSERT_CLK(a_out_drained, i_clk, i_rst_n, (r_state == S_OUT) |-> (!r_rd_valid && !r_p_valid))
    `ASSERT_CLK(a_idle_empty, i_clk, i_rst_n, (r_state == S_IDLE) |-> (!r_rd_valid && !r_p_valid))

endmodule

// ===== sv/lbsm_wdiv.sv =====
// ----------------------------------------------------------------------------
// lbsm_wdiv
// four parallel restoring dividers, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbsm_wdiv
    import lbsm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int unsigned REM_W = SUM_W + 1;
    localparam logic [4:0] LAST_STEP = 5'(WGT_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [4:0]            r_cnt;
    logic [SUM_W-1:0]      r_sum;
    logic [NUM_INF-1:0]    r_lsb;
    logic [REM_W-1:0]      r_rem [NUM_INF];
    logic [WGT_W-1:0]      r_q   [NUM_INF];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [REM_W-1:0] t;
        if (i_req.start) begin
            r_sum <= i_req.sum;
            for (int k = 0; k < NUM_INF; k++) begin
                r_rem[k] <= REM_W'(i_req.frac[k][FRAC_W-1:1]);
                r_lsb[k] <= i_req.frac[k][0];
                r_q[k]   <= '0;
            end
        end else if (r_busy) begin
            for (int k = 0; k < NUM_INF; k++) begin
                t = {r_rem[k][REM_W-2:0], (r_cnt == 5'd0) ? r_lsb[k] : 1'b0};
                if (t >= {1'b0, r_sum}) begin
                    r_rem[k] <= t - {1'b0, r_sum};
                    r_q[k]   <= {r_q[k][WGT_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= t;
                    r_q[k]   <= {r_q[k][WGT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        o_rsp.busy = r_busy;
        o_rsp.done = r_done;
        for (int k = 0; k < NUM_INF; k++) begin
            o_rsp.w[k] = r_q[k];
        end
    end

    `ASSERT_NEVER(a_start_busy, i_clk, i_rst_n, i_req.start && r_busy)
    `ASSERT_CLK(a_rem_below, i_clk, i_rst_n, r_busy |-> (r_rem[0] < {1'b0, r_sum}))
    `ASSERT_CLK(a_done_ends, i_clk, i_rst_n, r_done |-> !r_busy)

endmodule

// ===== tb/tb_linear_blend_skin_matrix_core.sv =====
// ----------------------------------------------------------------------------
// tb_linear_blend_skin_matrix_core
// self-checking bench for the four-influence skinning matrix blend core
// ----------------------------------------------------------------------------
// palette loads and blend beats go in over the valid/stall channel. a
// scoreboard keeps its own palette and check flag, computes the four blended
// rows of each vertex and compares every row beat as it leaves the core.
// the check flag is changed over the apb port between phases, when idle.
// ----------------------------------------------------------------------------
module tb_linear_blend_skin_matrix_core;
    import lbsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ENTRIES = 128;
    localparam int unsigned LIMIT   = 400000;

    class skin_scoreboard;
        logic signed [31:0] palette [ENTRIES*16];
        bit                 written [ENTRIES];
        bit                 bad_check;
        t_out_beat          rows_due [$];
        int                 errors;
        int                 row_count;

        function new();
            bad_check = 1'b1;
            errors    = 0;
            row_count = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function logic signed [31:0] round_sat(logic signed [63:0] acc);
            logic signed [63:0] r;
            r = (acc + 64'sd32768) >>> 16;
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return r[31:0];
        endfunction

        function void note_beat(t_in_beat b);
            logic [23:0]        inf [4];
            int unsigned        joint [4];
            logic [63:0]        frac [4];
            logic [63:0]        wgt [4];
            logic [63:0]        total;
            logic signed [63:0] acc;
            t_out_beat          o;
            bit                 bad;
            if (b.command == CMD_LOAD) begin
                palette[b.joint_entry*16 + b.element_slot] = b.element_value;
                written[b.joint_entry] = 1'b1;
                return;
            end
            inf[0] = b.influence_a;
            inf[1] = b.influence_b;
            inf[2] = b.influence_c;
            inf[3] = b.influence_d;
            total = '0;
            for (int k = 0; k < 4; k++) begin
                joint[k] = 32'(inf[k][23:16]);
                if (joint[k] > ENTRIES - 1) joint[k] = ENTRIES - 1;
                frac[k] = 64'(inf[k][15:0]);
                total += frac[k];
            end
            bad = 1'b0;
            if (total == 0) begin
                wgt[0] = 64'd65536;
                wgt[1] = 64'd0;
                wgt[2] = 64'd0;
                wgt[3] = 64'd0;
                bad = bad_check;
            end else begin
                for (int k = 0; k < 4; k++) wgt[k] = (frac[k] << 16) / total;
            end
            for (int r = 0; r < 4; r++) begin
                o = '0;
                o.row_number = 2'(r);
                for (int c = 0; c < 4; c++) begin
                    acc = '0;
                    for (int k = 0; k < 4; k++)
                        acc += 64'(palette[joint[k]*16 + r*4 + c]) * $signed(wgt[k]);
                    case (c)
                        0: o.col_zero  = round_sat(acc);
                        1: o.col_one   = round_sat(acc);
                        2: o.col_two   = round_sat(acc);
                        default: o.col_three = round_sat(acc);
                    endcase
                end
                o.last_row    = (r == 3);
                o.weights_bad = bad;
                rows_due.push_back(o);
            end
        endfunction

        function void check_row(t_out_beat got);
            t_out_beat e;
            row_count++;
            if (rows_due.size() == 0) begin
                $error("unexpected row beat %p", got);
                errors++;
                return;
            end
            e = rows_due.pop_front();
            if (got.row_number !== e.row_number) begin
                $error("row_number exp %0d got %0d", e.row_number, got.row_number);
                errors++;
            end
            if (got.col_zero !== e.col_zero) begin
                $error("col_zero exp %0h got %0h", e.col_zero, got.col_zero);
                errors++;
            end
            if (got.col_one !== e.col_one) begin
                $error("col_one exp %0h got %0h", e.col_one, got.col_one);
                errors++;
            end
            if (got.col_two !== e.col_two) begin
                $error("col_two exp %0h got %0h", e.col_two, got.col_two);
                errors++;
            end
            if (got.col_three !== e.col_three) begin
                $error("col_three exp %0h got %0h", e.col_three, got.col_three);
                errors++;
            end
            if (got.last_row !== e.last_row) begin
                $error("last_row exp %0d got %0d", e.last_row, got.last_row);
                errors++;
            end
            if (got.weights_bad !== e.weights_bad) begin
                $error("weights_bad exp %0d got %0d", e.weights_bad, got.weights_bad);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_beat    i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_beat   o_out;

    skin_scoreboard sb;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          cycles = 0;
    int          blends = 0;
    int          loads = 0;

    always #5 i_clk = ~i_clk;

    linear_blend_skin_matrix_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_row(o_out);
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic write_check(bit v);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {REG_BAD_SCALE_CHECK, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_FFFE) | {31'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.bad_check = v;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_beat(t_in_beat b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(b);
        if (b.command == CMD_LOAD) loads++;
        else blends++;
    endtask

    task automatic load_elem(int unsigned e, int unsigned s, logic [31:0] v);
        t_in_beat b;
        b = $bits(t_in_beat)'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        b.command       = CMD_LOAD;
        b.joint_entry   = 7'(e);
        b.element_slot  = 4'(s);
        b.element_value = v;
        send_beat(b);
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(131072) - 65536;
            default: return $urandom();
        endcase
    endfunction

    function automatic int unsigned rand_loaded();
        int unsigned e;
        do e = $urandom_range(ENTRIES - 1); while (!sb.written[e]);
        return e;
    endfunction

    task automatic load_matrix(int unsigned e);
        for (int s = 0; s < 16; s++) load_elem(e, s, rand_elem());
    endtask

    function automatic logic [23:0] rand_inf();
        logic [7:0]  j;
        logic [15:0] f;
        do j = 8'($urandom()); while (!sb.written[j > 127 ? 127 : j]);
        case ($urandom_range(4))
            0: f = 16'h0000;
            1: f = 16'hFFFF;
            default: f = 16'($urandom());
        endcase
        return {j, f};
    endfunction

    task automatic blend(logic [23:0] a, logic [23:0] b2, logic [23:0] c,
                         logic [23:0] d);
        t_in_beat b;
        b = $bits(t_in_beat)'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        b.command     = CMD_BLEND;
        b.influence_a = a;
        b.influence_b = b2;
        b.influence_c = c;
        b.influence_d = d;
        send_beat(b);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.rows_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 2)
                load_elem(rand_loaded(), $urandom_range(15), rand_elem());
            else if ($urandom_range(19) == 0)
                blend({rand_inf() & 24'hFF0000}, {rand_inf() & 24'hFF0000},
                      {rand_inf() & 24'hFF0000}, {rand_inf() & 24'hFF0000});
            else
                blend(rand_inf(), rand_inf(), rand_inf(), rand_inf());
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // palette fill: low, high and a middle entry
        load_matrix(0);
        load_matrix(127);
        load_matrix(1);
        load_matrix(64);

        blend(24'h00_FFFF, 24'h7F_FFFF, 24'h01_FFFF, 24'h40_FFFF);
        blend(24'hFF_0001, 24'h80_0000, 24'h00_0000, 24'h00_0000);
        blend(24'h00_0000, 24'h7F_0000, 24'hFF_0000, 24'h01_0000);
        blend(24'h00_8000, 24'h00_0000, 24'h00_0000, 24'h00_0000);
        blend(24'hC0_0001, 24'h01_0001, 24'h40_0001, 24'h7F_0001);
        drain();
        write_check(1'b0);
        blend(24'h40_0000, 24'h01_0000, 24'h00_0000, 24'hFE_0000);
        blend(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF);
        drain();
        write_check(1'b1);

        send_idle_pct = 10;
        stall_pct     = 49;
        random_phase(36);
        drain();
        write_check(1'b0);
        send_idle_pct = 49;
        stall_pct     = 10;
        random_phase(36);
        drain();
        write_check(1'b1);
        send_idle_pct = 0;
        stall_pct     = 0;
        random_phase(36);
        drain();

        $display("covered %0d palette loads and %0d vertex blends, %0d row beats checked",
                 loads, blends, sb.row_count);
        $display("with zero weight sums, clamped joints and check flag both ways");
        if (sb.errors == 0 && sb.rows_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
